// File: rtl/dsuf_pkg.sv
`default_nettype none

package dsuf_pkg;

   localparam int ELEM_W           = 11;
   localparam int OP_W             = 2;
   localparam int RANK_W           = 4;
   localparam int MAX_ELEMENTS_DEF = 1024;

   localparam logic [ELEM_W-1:0] SET_SIZE_RESET = ELEM_W'(1024);
   localparam logic [RANK_W-1:0] RANK_MAX       = '1;

   typedef enum logic [OP_W-1:0] {
      OP_UNION    = 2'd0,
      OP_COMPRESS = 2'd1,
      OP_PEEK     = 2'd2,
      OP_SPARE    = 2'd3
   } op_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tbl_ctl_type;

endpackage

`default_nettype wire

// File: rtl/disjoint_set_union_find_top.sv
// a request walks one link per cycle through the single table read port; a find without
// change strobes its response once it reaches the root, a find with compression also
// rewrites the path to the root, a union does both walks and links, one more step on equal ranks
// throughput: one request at a time, busy stays high until the response strobe is issued
// reset: synchronous; afterwards busy holds high while the table clears, csr writes are
// taken throughout, and the response strobe cannot be stalled
`default_nettype none

module disjoint_set_union_find_top
   import dsuf_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [OP_W-1:0]   req_opcode,
   input  wire logic [ELEM_W-1:0] req_elem_a,
   input  wire logic [ELEM_W-1:0] req_elem_b,
   output logic                   rsp_valid,
   output logic      [ELEM_W-1:0] rsp_root,
   output logic                   rsp_merged,
   output logic                   rsp_status,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [ELEM_W-1:0] csr_set_size
);

   localparam int IDXW  = $clog2(MAX_ELEMENTS + 1);
   localparam int EW    = RANK_W + IDXW;
   localparam int CMP_W = (IDXW > ELEM_W) ? IDXW : ELEM_W;

   logic [ELEM_W-1:0] set_size_ff;
   logic [ELEM_W-1:0] set_size_in;
   logic [CMP_W-1:0]  eff_size;
   tbl_ctl_type       tbl_ctl;
   logic [IDXW-1:0]   rd_addr;
   logic [IDXW-1:0]   wr_addr;
   logic [EW-1:0]     wr_data;
   logic [EW-1:0]     rd_data;
   logic              clearing;

   assign csr_ready   = 1'b1;
   assign set_size_in = (csr_valid && csr_ready) ? csr_set_size : set_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= SET_SIZE_RESET;
      end else begin
         set_size_ff <= set_size_in;
      end
   end

   // sizes above the table depth act as the full table
   assign eff_size = (CMP_W'(set_size_ff) > CMP_W'(MAX_ELEMENTS)) ?
                     CMP_W'(MAX_ELEMENTS) : CMP_W'(set_size_ff);

   dsuf_ctrl #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_elem_a (req_elem_a),
      .req_elem_b (req_elem_b),
      .eff_size   (eff_size),
      .clearing   (clearing),
      .tbl_ctl    (tbl_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_data    (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_root   (rsp_root),
      .rsp_merged (rsp_merged),
      .rsp_status (rsp_status)
   );

   dsuf_table #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tbl_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_data_ff (rd_data),
      .clearing   (clearing)
   );

endmodule

`default_nettype wire

// File: rtl/dsuf_table.sv
`default_nettype none

module dsuf_table
   import dsuf_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire tbl_ctl_type                                 ctl,
   input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]           rd_addr,
   input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]           wr_addr,
   input  wire logic [RANK_W+$clog2(MAX_ELEMENTS+1)-1:0]    wr_data,
   output logic      [RANK_W+$clog2(MAX_ELEMENTS+1)-1:0]    rd_data_ff,
   output logic                                             clearing
);

   localparam int IDXW = $clog2(MAX_ELEMENTS + 1);
   localparam int EW   = RANK_W + IDXW;

   // entry: rank above, parent below
   logic [EW-1:0]   mem [0:MAX_ELEMENTS];
   logic            clr_active_ff;
   logic            clr_active_in;
   logic [IDXW-1:0] clr_cnt_ff;
   logic [IDXW-1:0] clr_cnt_in;

   assign clearing = clr_active_ff;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         if (clr_cnt_ff == IDXW'(MAX_ELEMENTS)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + IDXW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
      end
   end

   // clearing sweep: each entry points at itself with rank zero
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_cnt_ff] <= {RANK_W'(0), clr_cnt_ff};
      end else if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/dsuf_ctrl.sv
`default_nettype none

module dsuf_ctrl
   import dsuf_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  wire logic                                                    clock,
   input  wire logic                                                    reset,
   input  wire logic                                                    start,
   output logic                                                         busy,
   input  wire logic [OP_W-1:0]                                         req_opcode,
   input  wire logic [ELEM_W-1:0]                                       req_elem_a,
   input  wire logic [ELEM_W-1:0]                                       req_elem_b,
   input  wire logic [(($clog2(MAX_ELEMENTS+1) > ELEM_W) ?
                       $clog2(MAX_ELEMENTS+1) : ELEM_W)-1:0]            eff_size,
   input  wire logic                                                    clearing,
   output tbl_ctl_type                                                  tbl_ctl,
   output logic      [$clog2(MAX_ELEMENTS+1)-1:0]                       rd_addr,
   output logic      [$clog2(MAX_ELEMENTS+1)-1:0]                       wr_addr,
   output logic      [RANK_W+$clog2(MAX_ELEMENTS+1)-1:0]                wr_data,
   input  wire logic [RANK_W+$clog2(MAX_ELEMENTS+1)-1:0]                rd_data,
   output logic                                                         rsp_valid,
   output logic      [ELEM_W-1:0]                                       rsp_root,
   output logic                                                         rsp_merged,
   output logic                                                         rsp_status
);

   localparam int IDXW  = $clog2(MAX_ELEMENTS + 1);
   localparam int EW    = RANK_W + IDXW;
   localparam int CMP_W = (IDXW > ELEM_W) ? IDXW : ELEM_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,
      ST_COMP = 5'b00100,
      ST_LINK = 5'b01000,
      ST_BUMP = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   logic [IDXW-1:0] a_ff, a_in, b_ff, b_in, cur_ff, cur_in;
   logic [IDXW-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [RANK_W-1:0] rka_ff, rka_in, rkb_ff, rkb_in;
   logic            phase_ff, phase_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_root_ff, rsp_root_in;
   logic            rsp_merged_ff, rsp_merged_in;
   logic            rsp_status_ff, rsp_status_in;

   logic [IDXW-1:0]   par;
   logic [RANK_W-1:0] rk;
   logic [IDXW-1:0]   path_start;
   logic [IDXW-1:0]   comp_root;
   logic              advance;
   logic [IDXW-1:0]   adv_root;
   logic              a_ok, b_ok;
   op_type            req_op;

   assign par        = rd_data[IDXW-1:0];
   assign rk         = rd_data[EW-1:IDXW];
   assign path_start = phase_ff ? b_ff : a_ff;
   assign comp_root  = phase_ff ? rb_ff : ra_ff;
   assign req_op     = op_type'(req_opcode);
   assign a_ok = (req_elem_a != '0) && (CMP_W'(req_elem_a) <= eff_size);
   assign b_ok = (req_elem_b != '0) && (CMP_W'(req_elem_b) <= eff_size);

   assign busy       = (state_ff != ST_IDLE) || clearing;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_root   = rsp_root_ff;
   assign rsp_merged = rsp_merged_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      cur_in        = cur_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      rka_in        = rka_ff;
      rkb_in        = rkb_ff;
      phase_in      = phase_ff;
      rsp_valid_in  = 1'b0;
      rsp_root_in   = rsp_root_ff;
      rsp_merged_in = rsp_merged_ff;
      rsp_status_in = rsp_status_ff;
      tbl_ctl       = '0;
      rd_addr       = cur_ff;
      wr_addr       = cur_ff;
      wr_data       = '0;
      advance       = 1'b0;
      adv_root      = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start && !clearing) begin
               if (!a_ok || (req_op == OP_UNION && !b_ok)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_root_in   = '0;
                  rsp_merged_in = 1'b0;
                  rsp_status_in = 1'b1;
               end else begin
                  op_in         = req_op;
                  a_in          = IDXW'(req_elem_a);
                  b_in          = IDXW'(req_elem_b);
                  cur_in        = IDXW'(req_elem_a);
                  phase_in      = 1'b0;
                  tbl_ctl.rd_en = 1'b1;
                  rd_addr       = IDXW'(req_elem_a);
                  state_in      = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (par == cur_ff) begin
               if (phase_ff) begin
                  rb_in  = cur_ff;
                  rkb_in = rk;
               end else begin
                  ra_in  = cur_ff;
                  rka_in = rk;
               end
               if (op_ff != OP_UNION && op_ff != OP_COMPRESS) begin
                  rsp_valid_in  = 1'b1;
                  rsp_root_in   = ELEM_W'(cur_ff);
                  rsp_merged_in = 1'b0;
                  rsp_status_in = 1'b0;
                  state_in      = ST_IDLE;
               end else if (path_start == cur_ff) begin
                  advance  = 1'b1;
                  adv_root = cur_ff;
               end else begin
                  tbl_ctl.rd_en = 1'b1;
                  rd_addr       = path_start;
                  cur_in        = path_start;
                  state_in      = ST_COMP;
               end
            end else begin
               tbl_ctl.rd_en = 1'b1;
               rd_addr       = par;
               cur_in        = par;
            end
         end

         // second pass: point each node of the path at the root
         ST_COMP: begin
            tbl_ctl.wr_en = 1'b1;
            wr_addr       = cur_ff;
            wr_data       = {rk, comp_root};
            if (par == comp_root) begin
               advance  = 1'b1;
               adv_root = comp_root;
            end else begin
               tbl_ctl.rd_en = 1'b1;
               rd_addr       = par;
               cur_in        = par;
            end
         end

         ST_LINK: begin
            rsp_status_in = 1'b0;
            if (ra_ff == rb_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_root_in   = ELEM_W'(ra_ff);
               rsp_merged_in = 1'b0;
               state_in      = ST_IDLE;
            end else if (rka_ff > rkb_ff) begin
               tbl_ctl.wr_en = 1'b1;
               wr_addr       = rb_ff;
               wr_data       = {rkb_ff, ra_ff};
               rsp_valid_in  = 1'b1;
               rsp_root_in   = ELEM_W'(ra_ff);
               rsp_merged_in = 1'b1;
               state_in      = ST_IDLE;
            end else if (rka_ff < rkb_ff) begin
               tbl_ctl.wr_en = 1'b1;
               wr_addr       = ra_ff;
               wr_data       = {rka_ff, rb_ff};
               rsp_valid_in  = 1'b1;
               rsp_root_in   = ELEM_W'(rb_ff);
               rsp_merged_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               tbl_ctl.wr_en = 1'b1;
               wr_addr       = rb_ff;
               wr_data       = {rkb_ff, ra_ff};
               state_in      = ST_BUMP;
            end
         end

         // equal ranks: the surviving root gains one, saturating
         ST_BUMP: begin
            tbl_ctl.wr_en = 1'b1;
            wr_addr       = ra_ff;
            wr_data       = {(rka_ff == RANK_MAX) ? rka_ff : rka_ff + RANK_W'(1), ra_ff};
            rsp_valid_in  = 1'b1;
            rsp_root_in   = ELEM_W'(ra_ff);
            rsp_merged_in = 1'b1;
            rsp_status_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (op_ff == OP_UNION && !phase_ff) begin
            phase_in      = 1'b1;
            cur_in        = b_ff;
            tbl_ctl.rd_en = 1'b1;
            rd_addr       = b_ff;
            state_in      = ST_WALK;
         end else if (op_ff == OP_UNION) begin
            state_in = ST_LINK;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_root_in   = ELEM_W'(adv_root);
            rsp_merged_in = 1'b0;
            rsp_status_in = 1'b0;
            state_in      = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      cur_ff        <= cur_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      rka_ff        <= rka_in;
      rkb_ff        <= rkb_in;
      phase_ff      <= phase_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_merged_ff <= rsp_merged_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire
